/* hw/rtl/des_pkg.sv */
`timescale 1ns / 1ps

package des_pkg;

  localparam int ROUNDS = 16;

  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
    logic        op;
  } des_state_t;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Total left rotation of C and D after each round.
  localparam logic [4:0] KS_SHIFT [ROUNDS] = '{
    5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
  };

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  // In every permutation table, entry 1 names the most significant bit of the source.
  function automatic logic [63:0] ip_perm(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) begin
      o[63 - i] = v[64 - int'(IP_TAB[i])];
    end
    return o;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) begin
      o[63 - i] = v[64 - int'(FP_TAB[i])];
    end
    return o;
  endfunction

  function automatic logic [47:0] e_expand(input logic [31:0] v);
    logic [47:0] o;
    for (int i = 0; i < 48; i++) begin
      o[47 - i] = v[32 - int'(E_TAB[i])];
    end
    return o;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] v);
    logic [31:0] o;
    for (int i = 0; i < 32; i++) begin
      o[31 - i] = v[32 - int'(P_TAB[i])];
    end
    return o;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] v);
    logic [55:0] o;
    for (int i = 0; i < 56; i++) begin
      o[55 - i] = v[64 - int'(PC1_TAB[i])];
    end
    return o;
  endfunction

  function automatic logic [47:0] pc2_perm(input logic [55:0] v);
    logic [47:0] o;
    for (int i = 0; i < 48; i++) begin
      o[47 - i] = v[56 - int'(PC2_TAB[i])];
    end
    return o;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] v, input logic [4:0] n);
    logic [55:0] dbl;
    dbl = {v, v};
    return dbl[55 - int'(n) -: 28];
  endfunction

  // Called with a constant round number, so this reduces to wiring.
  function automatic logic [47:0] subkey(input logic [63:0] key, input int rnd);
    logic [55:0] k56;
    logic [27:0] c;
    logic [27:0] d;
    k56 = pc1_perm(key);
    c = rot28(k56[55:28], KS_SHIFT[rnd]);
    d = rot28(k56[27:0], KS_SHIFT[rnd]);
    return pc2_perm({c, d});
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [5:0]  g;
    logic [31:0] s;
    x = e_expand(r) ^ k;
    for (int i = 0; i < 8; i++) begin
      g = x[47 - 6 * i -: 6];
      s[31 - 4 * i -: 4] = SBOX[i][{g[5], g[0], g[4:1]}];
    end
    return p_perm(s);
  endfunction

endpackage

/* hw/rtl/des_round.sv */
`timescale 1ns / 1ps

module des_round (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_vld,
  input  des_pkg::des_state_t  in_st,
  input  logic [47:0]          ks_enc,
  input  logic [47:0]          ks_dec,
  output logic                 out_vld,
  output des_pkg::des_state_t  out_st
);

  logic [47:0]         round_key;
  des_pkg::des_state_t st_next;

  always_comb begin
    round_key  = in_st.op ? ks_dec : ks_enc;
    st_next.l  = in_st.r;
    st_next.r  = in_st.l ^ des_pkg::feistel(in_st.r, round_key);
    st_next.op = in_st.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_st <= st_next;
    end
  end

endmodule

/* hw/rtl/des_block_cipher_unit.sv */
`timescale 1ns / 1ps

// DES block cipher in ECB mode, fully unrolled into a pipeline of one register stage per
// round plus an output register, so a new 64-bit block can enter on every clock while the
// output side does not stall. The whole pipeline holds while a finished result is stalled
// at the output. The key is written through cipher_key_wr_en and cipher_key_wr_data and
// must only change while the pipeline is empty; the round subkeys are derived from it by
// wiring alone.

module des_block_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cipher_key_wr_en,
  input  logic [63:0] cipher_key_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_block,
  input  logic        operation,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_block
);

  logic [63:0]                              cipher_key;
  logic [47:0]                              subkeys [des_pkg::ROUNDS];
  logic [des_pkg::ROUNDS:0]                 vld;
  des_pkg::des_state_t                      st [des_pkg::ROUNDS + 1];
  logic [63:0]                              ip_block;
  logic                                     advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= 64'd0;
    end else if (cipher_key_wr_en) begin
      cipher_key <= cipher_key_wr_data;
    end
  end

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  assign ip_block  = des_pkg::ip_perm(data_block);
  assign vld[0]    = in_valid;
  assign st[0].l   = ip_block[63:32];
  assign st[0].r   = ip_block[31:0];
  assign st[0].op  = operation;

  for (genvar r = 0; r < des_pkg::ROUNDS; r++) begin : g_round
    assign subkeys[r] = des_pkg::subkey(cipher_key, r);

    des_round u_round (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .in_vld  (vld[r]),
      .in_st   (st[r]),
      .ks_enc  (subkeys[r]),
      .ks_dec  (subkeys[des_pkg::ROUNDS - 1 - r]),
      .out_vld (vld[r + 1]),
      .out_st  (st[r + 1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld[des_pkg::ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_block <= des_pkg::fp_perm({st[des_pkg::ROUNDS].r, st[des_pkg::ROUNDS].l});
    end
  end

  a_freeze_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vld[des_pkg::ROUNDS:1]))
    else $error("round pipeline moved while the output beat was stalled");

  a_last_round_drains: assert property (@(posedge clk) disable iff (rst)
    (vld[des_pkg::ROUNDS] && !in_stall) |=> out_valid)
    else $error("beat from the last round did not reach the output register");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && vld[des_pkg::ROUNDS:1] == '0))
    else $error("pipeline not empty after reset");

  a_bubble_moves: assert property (@(posedge clk) disable iff (rst)
    (!vld[des_pkg::ROUNDS] && !in_stall) |=> !out_valid)
    else $error("output beat appeared without a beat in the last round");

endmodule

/* dv/des_block_cipher_unit_tb.sv */
`timescale 1ns / 1ps

module des_block_cipher_unit_tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int BLOCKS_PER_PHASE = 450;
  localparam int DRAIN_CYCLES = 24;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } cipher_op_t;

  typedef enum int {
    PT_IP,
    PT_FP,
    PT_E,
    PT_P,
    PT_PC1,
    PT_PC2
  } perm_table_t;

  typedef struct packed {
    logic        load_key;
    logic [63:0] key;
    logic [63:0] blk;
    cipher_op_t  op;
    logic        known;
    logic [63:0] answer;
  } directed_row_t;

  localparam int IP_MAP [64] = '{
    58, 50, 42, 34, 26, 18, 10, 2, 60, 52, 44, 36, 28, 20, 12, 4,
    62, 54, 46, 38, 30, 22, 14, 6, 64, 56, 48, 40, 32, 24, 16, 8,
    57, 49, 41, 33, 25, 17, 9, 1, 59, 51, 43, 35, 27, 19, 11, 3,
    61, 53, 45, 37, 29, 21, 13, 5, 63, 55, 47, 39, 31, 23, 15, 7
  };

  localparam int E_MAP [48] = '{
    32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9, 8, 9, 10, 11, 12, 13,
    12, 13, 14, 15, 16, 17, 16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
    24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1
  };

  localparam int P_MAP [32] = '{
    16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
    2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
  };

  localparam int PC1_MAP [56] = '{
    57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
    10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
    14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4
  };

  localparam int PC2_MAP [48] = '{
    14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10, 23, 19, 12, 4, 26, 8,
    16, 7, 27, 20, 13, 2, 41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
    44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
  };

  localparam int KEY_ROT [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

  // Each word is one S-box row; the column selects a nibble, column 0 on top.
  localparam logic [63:0] SBOX_ROWS [32] = '{
    64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538, 64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
    64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5, 64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
    64'hA09E63F51DC7B428, 64'hD709346A285ECBF1, 64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
    64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9, 64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
    64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986, 64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
    64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38, 64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
    64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86, 64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
    64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92, 64'h7B419CE206ADF358, 64'h21E74A8DFC90356B
  };

  localparam int N_DIRECTED = 18;

  // A key whose only set bits are parity bits acts as the all-zero key.
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, 64'h0, 64'h0, OP_ENCRYPT, 1'b1, 64'h8CA64DE9C1B123A7},
    '{1'b0, 64'h0, 64'h8CA64DE9C1B123A7, OP_DECRYPT, 1'b1, 64'h0},
    '{1'b0, 64'h0, 64'hFFFFFFFFFFFFFFFF, OP_ENCRYPT, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'hFFFFFFFFFFFFFFFF, OP_DECRYPT, 1'b0, 64'h0},
    '{1'b1, 64'h0101010101010101, 64'h0, OP_ENCRYPT, 1'b1, 64'h8CA64DE9C1B123A7},
    '{1'b1, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, OP_ENCRYPT, 1'b1, 64'h7359B2163E4EDC58},
    '{1'b0, 64'h0, 64'h7359B2163E4EDC58, OP_DECRYPT, 1'b1, 64'hFFFFFFFFFFFFFFFF},
    '{1'b1, 64'hFEFEFEFEFEFEFEFE, 64'hFFFFFFFFFFFFFFFF, OP_ENCRYPT, 1'b1, 64'h7359B2163E4EDC58},
    '{1'b1, 64'h133457799BBCDFF1, 64'h0123456789ABCDEF, OP_ENCRYPT, 1'b1, 64'h85E813540F0AB405},
    '{1'b0, 64'h0, 64'h85E813540F0AB405, OP_DECRYPT, 1'b1, 64'h0123456789ABCDEF},
    '{1'b0, 64'h0, 64'h0, OP_ENCRYPT, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'hFFFFFFFFFFFFFFFF, OP_DECRYPT, 1'b0, 64'h0},
    '{1'b1, 64'h0123456789ABCDEF, 64'h4E6F772069732074, OP_ENCRYPT, 1'b1, 64'h3FA40E8A984D4815},
    '{1'b0, 64'h0, 64'h3FA40E8A984D4815, OP_DECRYPT, 1'b1, 64'h4E6F772069732074},
    '{1'b0, 64'h0, 64'h8000000000000000, OP_ENCRYPT, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'h0000000000000001, OP_DECRYPT, 1'b0, 64'h0},
    '{1'b1, 64'h8000000000000000, 64'hAAAAAAAAAAAAAAAA, OP_ENCRYPT, 1'b0, 64'h0},
    '{1'b1, 64'h0000000000000001, 64'h0, OP_ENCRYPT, 1'b1, 64'h8CA64DE9C1B123A7}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        cipher_key_wr_en = 1'b0;
  logic [63:0] cipher_key_wr_data = 64'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] data_block = 64'd0;
  logic        operation = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_block;

  logic [63:0] pending_results [$];
  logic [63:0] oldest_result;
  logic [63:0] active_key = 64'd0;
  int          fp_map [64];
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          bad_results = 0;
  int          cycles = 0;

  des_block_cipher_unit i_dut (
    .clk                (clk),
    .rst                (rst),
    .cipher_key_wr_en   (cipher_key_wr_en),
    .cipher_key_wr_data (cipher_key_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .data_block         (data_block),
    .operation          (operation),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .result_block       (result_block)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int map_entry(input perm_table_t t, input int i);
    case (t)
      PT_IP:   return IP_MAP[i];
      PT_FP:   return fp_map[i];
      PT_E:    return E_MAP[i];
      PT_P:    return P_MAP[i];
      PT_PC1:  return PC1_MAP[i];
      default: return PC2_MAP[i];
    endcase
  endfunction

  function automatic logic [63:0] permute_bits(input logic [63:0] v, input int in_w,
                                               input perm_table_t t, input int n);
    logic [63:0] o;
    o = 64'd0;
    for (int i = 0; i < n; i++) begin
      o = {o[62:0], v[in_w - map_entry(t, i)]};
    end
    return o;
  endfunction

  function automatic logic [31:0] round_mix(input logic [31:0] r, input logic [47:0] k);
    logic [63:0] wide;
    logic [47:0] x;
    logic [5:0]  g;
    logic [31:0] s;
    int          row;
    int          col;
    wide = permute_bits({32'd0, r}, 32, PT_E, 48);
    x = wide[47:0] ^ k;
    s = 32'd0;
    for (int i = 0; i < 8; i++) begin
      g = x[47 - 6 * i -: 6];
      row = int'({g[5], g[0]});
      col = int'(g[4:1]);
      s = {s[27:0], SBOX_ROWS[4 * i + row][63 - 4 * col -: 4]};
    end
    wide = permute_bits({32'd0, s}, 32, PT_P, 32);
    return wide[31:0];
  endfunction

  function automatic logic [63:0] des_block(input logic [63:0] key, input logic [63:0] blk,
                                            input cipher_op_t op);
    logic [47:0] round_keys [16];
    logic [63:0] t;
    logic [27:0] c;
    logic [27:0] d;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] nl;
    t = permute_bits(key, 64, PT_PC1, 56);
    c = t[55:28];
    d = t[27:0];
    for (int rnd = 0; rnd < 16; rnd++) begin
      c = (c << KEY_ROT[rnd]) | (c >> (28 - KEY_ROT[rnd]));
      d = (d << KEY_ROT[rnd]) | (d >> (28 - KEY_ROT[rnd]));
      t = permute_bits({8'd0, c, d}, 56, PT_PC2, 48);
      round_keys[rnd] = t[47:0];
    end
    t = permute_bits(blk, 64, PT_IP, 64);
    l = t[63:32];
    r = t[31:0];
    for (int rnd = 0; rnd < 16; rnd++) begin
      nl = r;
      r = l ^ round_mix(r, round_keys[(op == OP_DECRYPT) ? 15 - rnd : rnd]);
      l = nl;
    end
    return permute_bits({r, l}, 64, PT_FP, 64);
  endfunction

  task automatic send_beat(input logic [63:0] blk, input cipher_op_t op,
                           input logic [63:0] answer);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_block <= blk;
    operation <= op;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_results = {pending_results, answer};
  endtask

  task automatic load_key(input logic [63:0] key);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    cipher_key_wr_en <= 1'b1;
    cipher_key_wr_data <= key;
    @(posedge clk);
    cipher_key_wr_en <= 1'b0;
    active_key = key;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat %h with no block pending", $time, result_block);
          bad_results++;
        end else begin
          oldest_result = pending_results.pop_front();
          if (result_block !== oldest_result) begin
            $display("%0t: result_block expected %h actual %h", $time, oldest_result,
                     result_block);
            bad_results++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  initial begin
    logic [63:0] key;
    logic [63:0] blk;
    logic [63:0] answer;
    logic [63:0] prev_result;
    cipher_op_t  op;
    cipher_op_t  prev_op;
    int          sent;
    int          run_len;
    for (int i = 0; i < 64; i++) begin
      fp_map[IP_MAP[i] - 1] = i + 1;
    end
    prev_result = 64'd0;
    prev_op = OP_ENCRYPT;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 14;
    receiver_stall_pct = 88;
    for (int n = 0; n < N_DIRECTED; n++) begin
      if (DIRECTED[n].load_key) begin
        load_key(DIRECTED[n].key);
      end
      answer = DIRECTED[n].known ? DIRECTED[n].answer :
               des_block(active_key, DIRECTED[n].blk, DIRECTED[n].op);
      send_beat(DIRECTED[n].blk, DIRECTED[n].op, answer);
    end

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 88 : 0;
      receiver_stall_pct = (phase == 0) ? 88 : (phase == 1) ? 14 : 0;
      sent = 0;
      while (sent < BLOCKS_PER_PHASE) begin
        case ($urandom_range(7))
          0:       key = 64'd0;
          1:       key = '1;
          default: key = {$urandom, $urandom};
        endcase
        load_key(key);
        run_len = $urandom_range(10, 60);
        for (int j = 0; j < run_len && sent < BLOCKS_PER_PHASE; j++) begin
          op = cipher_op_t'($urandom_range(1));
          case ($urandom_range(9))
            0:       blk = 64'd0;
            1:       blk = '1;
            // Feed the previous result back with the opposite operation for a round trip.
            2, 3: begin
              blk = prev_result;
              op = (prev_op == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT;
            end
            default: blk = {$urandom, $urandom};
          endcase
          answer = des_block(active_key, blk, op);
          send_beat(blk, op, answer);
          prev_result = answer;
          prev_op = op;
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* des_block_cipher_unit.f */
hw/rtl/des_pkg.sv
hw/rtl/des_round.sv
hw/rtl/des_block_cipher_unit.sv
dv/des_block_cipher_unit_tb.sv
